FILE: hdl/ddpq_pkg.sv
// Package for the due-date priority queue: field widths, codes, types.
// No dependencies.
package ddpq_pkg;
    localparam int DEPTH_DEFAULT = 32;
    localparam int MAX_RESULTS = 32;

    typedef enum logic [1:0] {REQ_INSERT, REQ_REMOVE, REQ_CLASS, REQ_HORIZON} req_t;
    typedef enum logic [2:0] {ST_OK, ST_INVALID, ST_DUP, ST_FULL, ST_NONE} status_t;
    localparam logic [2:0] COURSE_LIMIT = 3'd5;
    localparam logic [3:0] MONTHS = 4'd12;
    localparam logic [4:0] DAYS_PER_MONTH = 5'd30;

    typedef struct packed {
        logic [2:0]  course;
        logic [30:0] item_id;
        logic [3:0]  month;
        logic [4:0]  day;
    } entry_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [2:0]  course;
        logic [30:0] item_id;
        logic [3:0]  due_month;
        logic [4:0]  due_day;
        logic [3:0]  today_month;
        logic [4:0]  today_day;
        logic [9:0]  horizon_days;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  out_course;
        logic [30:0] out_item_id;
        logic [3:0]  out_month;
        logic [4:0]  out_day;
        logic [9:0]  days_left;
        logic        last;
    } out_word_t;

    typedef enum logic [2:0] {S_IDLE, S_DECIDE, S_SCAN, S_EMIT} state_t;

    typedef struct packed {
        logic load;
        logic do_insert;
        logic do_remove;
        logic scan_start;
        logic scan_step;
        logic emit_result;
        logic emit_final;
    } ctrl_t;

    typedef struct packed {
        logic is_insert;
        logic is_remove;
        logic is_class;
        logic imm_result;
        logic scan_done;
        logic match;
        logic last_hit;
    } stat_t;

    function automatic logic [8:0] day_number(input logic [3:0] m, input logic [4:0] d);
        return {m, 5'd0} - {4'd0, m, 1'b0} + {4'd0, d};
    endfunction
endpackage

FILE: hdl/ddpq_if.sv
// Valid/ready channel carrying one word of type T.
// Takes the word type as the parameter T; no dependencies.
interface ddpq_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/ddpq_ctrl.sv
// Sequencer for the queue: intake, horizon scan, result emission.
// Depends on ddpq_pkg.
module ddpq_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    output ddpq_pkg::ctrl_t ctrl,
    input  ddpq_pkg::stat_t stat
);
    ddpq_pkg::state_t state_reg, state_next;
    logic pend_reg, pend_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ddpq_pkg::S_IDLE;
            pend_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg <= pend_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pend_next = pend_reg;
        ctrl = '0;
        in_ready = 1'b0;
        out_valid = pend_reg;
        if (pend_reg && out_ready)
            pend_next = 1'b0;
        unique case (state_reg)
            ddpq_pkg::S_IDLE:
            begin
                in_ready = !pend_reg || out_ready;
                if (in_valid && in_ready)
                begin
                    ctrl.load = 1'b1;
                    state_next = ddpq_pkg::S_DECIDE;
                end
            end
            ddpq_pkg::S_DECIDE:
            begin
                if (stat.imm_result)
                begin
                    ctrl.do_insert = stat.is_insert;
                    ctrl.do_remove = stat.is_remove;
                    ctrl.emit_final = 1'b1;
                    pend_next = 1'b1;
                    state_next = ddpq_pkg::S_IDLE;
                end
                else
                begin
                    ctrl.scan_start = 1'b1;
                    state_next = ddpq_pkg::S_SCAN;
                end
            end
            ddpq_pkg::S_SCAN:
            begin
                if (!pend_next)
                begin
                    if (stat.scan_done)
                    begin
                        ctrl.emit_final = 1'b1;
                        pend_next = 1'b1;
                        state_next = ddpq_pkg::S_IDLE;
                    end
                    else if (stat.match)
                    begin
                        ctrl.emit_result = 1'b1;
                        ctrl.scan_step = 1'b1;
                        pend_next = 1'b1;
                        if (stat.last_hit)
                            state_next = ddpq_pkg::S_IDLE;
                    end
                    else
                        ctrl.scan_step = 1'b1;
                end
                else if (!stat.match && !stat.scan_done)
                    ctrl.scan_step = 1'b1;
            end
            default: state_next = ddpq_pkg::S_IDLE;
        endcase
    end
endmodule

FILE: hdl/ddpq_dp.sv
// Datapath: sorted shift cells, compare logic, scan pointer, result register.
// Depends on ddpq_pkg.
module ddpq_dp #(
    parameter int DEPTH = ddpq_pkg::DEPTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ddpq_pkg::in_word_t  in_data,
    input  ddpq_pkg::ctrl_t     ctrl,
    output ddpq_pkg::stat_t     stat,
    output ddpq_pkg::out_word_t out_data
);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);

    ddpq_pkg::entry_t cell_reg [DEPTH];
    logic [CW-1:0] count_reg;
    ddpq_pkg::in_word_t req_reg;
    logic [CW-1:0] ptr_reg;
    logic [5:0] nres_reg;
    ddpq_pkg::out_word_t out_reg;
    ddpq_pkg::out_word_t final_w;
    logic [DEPTH-1:0] dup_v, later_v, cls_v, hit_v, later_prev;
    logic [IW-1:0] cls_idx;
    logic cls_any;
    logic rest_any, more_any, last_hit;
    logic [8:0] key, today;
    logic signed [10:0] limit;
    logic field_bad;
    ddpq_pkg::entry_t new_e, cur_e;
    logic [8:0] cur_key;
    logic scan_end;

    assign new_e = '{req_reg.course, req_reg.item_id, req_reg.due_month, req_reg.due_day};
    assign key = ddpq_pkg::day_number(req_reg.due_month, req_reg.due_day);
    assign today = ddpq_pkg::day_number(req_reg.today_month, req_reg.today_day);
    assign limit = $signed({2'b00, today}) + 11'(signed'(req_reg.horizon_days));
    assign field_bad = req_reg.course > ddpq_pkg::COURSE_LIMIT || req_reg.due_month == 4'd0
        || req_reg.due_month > ddpq_pkg::MONTHS || req_reg.due_day == 5'd0
        || req_reg.due_day > ddpq_pkg::DAYS_PER_MONTH;

    always_comb
    begin
        cls_idx = '0;
        cls_any = 1'b0;
        rest_any = 1'b0;
        more_any = 1'b0;
        for (int i = 0; i < DEPTH; i++)
        begin
            dup_v[i] = CW'(i) < count_reg && cell_reg[i] == new_e;
            later_v[i] = CW'(i) < count_reg
                && ddpq_pkg::day_number(cell_reg[i].month, cell_reg[i].day) > key;
            cls_v[i] = CW'(i) < count_reg && cell_reg[i].course == req_reg.course;
            hit_v[i] = CW'(i) < count_reg && !req_reg.horizon_days[9]
                && $signed({2'b00, ddpq_pkg::day_number(cell_reg[i].month, cell_reg[i].day)})
                <= limit;
            if (hit_v[i] && CW'(i) >= ptr_reg)
                rest_any = 1'b1;
            if (hit_v[i] && CW'(i) > ptr_reg)
                more_any = 1'b1;
        end
        for (int i = DEPTH - 1; i >= 0; i--)
            if (cls_v[i])
            begin
                cls_any = 1'b1;
                cls_idx = IW'(i);
            end
    end

    assign later_prev = {later_v[DEPTH-2:0], 1'b0};

    assign cur_e = cell_reg[ptr_reg[IW-1:0]];
    assign cur_key = ddpq_pkg::day_number(cur_e.month, cur_e.day);
    assign scan_end = ptr_reg >= count_reg || nres_reg == 6'(ddpq_pkg::MAX_RESULTS);
    assign last_hit = !more_any || nres_reg == 6'(ddpq_pkg::MAX_RESULTS - 1);

    assign stat.is_insert = req_reg.req_type == ddpq_pkg::REQ_INSERT;
    assign stat.is_remove = req_reg.req_type == ddpq_pkg::REQ_REMOVE;
    assign stat.is_class = req_reg.req_type == ddpq_pkg::REQ_CLASS;
    assign stat.imm_result = req_reg.req_type != ddpq_pkg::REQ_HORIZON;
    assign stat.match = !scan_end && $signed({2'b00, cur_key}) <= limit
        && !req_reg.horizon_days[9];
    assign stat.scan_done = scan_end || req_reg.horizon_days[9] || !rest_any;
    assign stat.last_hit = last_hit;

    always_comb
    begin
        final_w = '0;
        final_w.last = 1'b1;
        unique case (req_reg.req_type)
            ddpq_pkg::REQ_INSERT:
                final_w.status = field_bad ? ddpq_pkg::ST_INVALID
                    : dup_v != '0 ? ddpq_pkg::ST_DUP
                    : count_reg == CW'(DEPTH) ? ddpq_pkg::ST_FULL : ddpq_pkg::ST_OK;
            ddpq_pkg::REQ_REMOVE:
                if (count_reg == '0)
                    final_w.status = ddpq_pkg::ST_NONE;
                else
                begin
                    final_w.status = ddpq_pkg::ST_OK;
                    final_w.out_course = cell_reg[0].course;
                    final_w.out_item_id = cell_reg[0].item_id;
                    final_w.out_month = cell_reg[0].month;
                    final_w.out_day = cell_reg[0].day;
                end
            ddpq_pkg::REQ_CLASS:
                if (req_reg.course > ddpq_pkg::COURSE_LIMIT)
                    final_w.status = ddpq_pkg::ST_INVALID;
                else if (!cls_any)
                    final_w.status = ddpq_pkg::ST_NONE;
                else
                begin
                    final_w.status = ddpq_pkg::ST_OK;
                    final_w.out_course = cell_reg[cls_idx].course;
                    final_w.out_item_id = cell_reg[cls_idx].item_id;
                    final_w.out_month = cell_reg[cls_idx].month;
                    final_w.out_day = cell_reg[cls_idx].day;
                    final_w.days_left = 10'($signed({1'b0, ddpq_pkg::day_number(
                        cell_reg[cls_idx].month, cell_reg[cls_idx].day)})
                        - $signed({1'b0, today}));
                end
            ddpq_pkg::REQ_HORIZON:
                final_w.status = ddpq_pkg::ST_NONE;
            default: final_w.status = ddpq_pkg::ST_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (ctrl.do_insert && !field_bad && dup_v == '0 && count_reg != CW'(DEPTH))
            count_reg <= count_reg + 1'b1;
        else if (ctrl.do_remove && count_reg != '0)
            count_reg <= count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
            req_reg <= in_data;
        if (ctrl.do_insert && !field_bad && dup_v == '0 && count_reg != CW'(DEPTH))
        begin
            for (int i = 0; i < DEPTH; i++)
                if (later_v[i] || CW'(i) == count_reg)
                    cell_reg[i] <= later_prev[i] ? cell_reg[(i == 0) ? 0 : i - 1] : new_e;
        end
        if (ctrl.do_remove)
            for (int i = 0; i < DEPTH - 1; i++)
                cell_reg[i] <= cell_reg[i+1];
        if (ctrl.scan_start)
        begin
            ptr_reg <= '0;
            nres_reg <= '0;
        end
        else if (ctrl.scan_step)
            ptr_reg <= ptr_reg + 1'b1;
        if (ctrl.emit_result)
        begin
            nres_reg <= nres_reg + 1'b1;
            out_reg <= '{ddpq_pkg::ST_OK, cur_e.course, cur_e.item_id, cur_e.month, cur_e.day,
                10'($signed({1'b0, cur_key}) - $signed({1'b0, today})), last_hit};
        end
        else if (ctrl.emit_final)
            out_reg <= final_w;
    end

    assign out_data = out_reg;
endmodule

FILE: hdl/due_date_priority_queue_unit.sv
// Due-date priority queue: DEPTH entries kept sorted by day number (30-day months),
// equal dates in arrival order. Insert, remove and class query register the word, then
// take one compare-and-shift step over the cells. A horizon query walks the cells one
// per cycle from the earliest and yields one result word per match (at most 32), or a
// single ST_NONE word if none match, with last on the final word; it is held back
// while the output register is full. Results sit in a single output register.
module due_date_priority_queue_unit #(
    parameter int DEPTH = ddpq_pkg::DEPTH_DEFAULT
) (
    input  logic clk,
    input  logic rst_n,
    ddpq_if.sink   req,
    ddpq_if.source rsp
);
    ddpq_pkg::ctrl_t ctrl;
    ddpq_pkg::stat_t stat;
    ddpq_pkg::out_word_t held;
    logic outv;

    ddpq_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(req.valid), .in_ready(req.ready),
        .out_valid(outv), .out_ready(rsp.ready), .ctrl(ctrl), .stat(stat)
    );

    ddpq_dp #(.DEPTH(DEPTH)) u_dp (
        .clk(clk), .rst_n(rst_n), .in_data(req.data), .ctrl(ctrl), .stat(stat),
        .out_data(held)
    );

    assign rsp.valid = outv;
    assign rsp.data = held;
endmodule
